// File: hdl/mcmc_pkg.sv
// ----------------------------------------------------------------------------
// mcmc_pkg
// Shared types, widths and helpers for the matrix-chain minimum-cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcmc_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned DIM_IN_W = 16;
  localparam int unsigned COST_O_W = 52;
  localparam int unsigned COUNT_O_W = 5;
  localparam int unsigned SPLIT_O_W = 4;

  // Internal cost width: sums saturate at the 64-bit maximum.
  localparam int unsigned COST_W = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CELL0,
    S_CELL1,
    S_CELL2,
    S_K0,
    S_K1,
    S_K2,
    S_K3,
    S_WR,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_BEST,
    OUT_OVF
  } out_kind_e;

  typedef struct packed {
    logic      dim_we;
    logic      dim_rd;
    logic      pim1_ld;
    logic      pj_ld;
    logic      best_init;
    logic      cost_rd;
    logic      a_zero;
    logic      b_zero;
    logic      mul1;
    logic      mul2;
    logic      acc;
    logic      cost_wr;
    logic      out_ld;
    out_kind_e out_kind;
  } cmd_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/mcmc_dpath.sv
// ----------------------------------------------------------------------------
// mcmc_dpath
// Dimension store, cost table memory, multipliers and best-split tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmc_dpath #(
  parameter int unsigned MAX_MATRICES = 16,
  parameter int unsigned DIM_BITS     = 16
) (
  input  wire logic                                clk_i,
  input  wire mcmc_pkg::cmd_t                      cmd_i,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]   dim_waddr_i,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]   dim_raddr_i,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]   i_i,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]   j_i,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]   k_i,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]   n_i,
  input  wire logic [mcmc_pkg::DIM_IN_W-1:0]       dim_value_i,
  output logic      [mcmc_pkg::COST_O_W-1:0]       min_cost_o,
  output logic      [mcmc_pkg::COUNT_O_W-1:0]      matrix_count_o,
  output logic      [mcmc_pkg::SPLIT_O_W-1:0]      top_split_o,
  output logic                                     too_many_o
);

  localparam int unsigned NDIM  = MAX_MATRICES + 1;
  localparam int unsigned IDX_W = $clog2(NDIM);
  localparam int unsigned DW    = (DIM_BITS < mcmc_pkg::DIM_IN_W) ? DIM_BITS
                                                                  : mcmc_pkg::DIM_IN_W;
  localparam int unsigned DEPTH = NDIM * NDIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = mcmc_pkg::COST_W;

  logic [DW-1:0]   dim_mem [NDIM];
  logic [CW-1:0]   cost_mem [DEPTH];

  logic [DW-1:0]   dim_rd_q;
  logic [DW-1:0]   pim1_q;
  logic [DW-1:0]   pj_q;
  logic [CW-1:0]   rda_q, rdb_q;
  logic [CW-1:0]   sum_q;
  logic [2*DW-1:0] prod1_q;
  logic [3*DW-1:0] prod2_q;
  logic [CW-1:0]   best_q;
  logic [IDX_W-1:0] best_k_q;
  logic [CW-1:0]   total;
  logic [IDX_W-1:0] k_next;
  logic [AW-1:0]   addr_a, addr_b, addr_w;

  assign k_next = k_i + IDX_W'(1);
  assign addr_a = AW'(i_i) * AW'(NDIM) + AW'(k_i);
  assign addr_b = AW'(k_next) * AW'(NDIM) + AW'(j_i);
  assign addr_w = AW'(i_i) * AW'(NDIM) + AW'(j_i);
  assign total  = mcmc_pkg::sat_add(sum_q, CW'(prod2_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.dim_we) begin
      dim_mem[dim_waddr_i] <= dim_value_i[DW-1:0];
    end
    if (cmd_i.dim_rd) begin
      dim_rd_q <= dim_mem[dim_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cost_wr) begin
      cost_mem[addr_w] <= best_q;
    end
    if (cmd_i.cost_rd) begin
      rda_q <= cost_mem[addr_a];
      rdb_q <= cost_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pim1_ld) pim1_q <= dim_rd_q;
    if (cmd_i.pj_ld)   pj_q   <= dim_rd_q;
    if (cmd_i.mul1) begin
      prod1_q <= (2*DW)'(pim1_q) * (2*DW)'(dim_rd_q);
      sum_q   <= mcmc_pkg::sat_add(cmd_i.a_zero ? '0 : rda_q,
                                   cmd_i.b_zero ? '0 : rdb_q);
    end
    if (cmd_i.mul2) begin
      prod2_q <= (3*DW)'(prod1_q) * (3*DW)'(pj_q);
    end
    if (cmd_i.best_init) begin
      best_q   <= '1;
      best_k_q <= i_i;
    end else if (cmd_i.acc && (total < best_q)) begin
      best_q   <= total;
      best_k_q <= k_i;
    end
  end

  // Result payload register; it only loads when the output side is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      unique case (cmd_i.out_kind)
        mcmc_pkg::OUT_BEST: begin
          min_cost_o     <= best_q[mcmc_pkg::COST_O_W-1:0];
          matrix_count_o <= mcmc_pkg::COUNT_O_W'(n_i);
          top_split_o    <= mcmc_pkg::SPLIT_O_W'(best_k_q);
          too_many_o     <= 1'b0;
        end
        mcmc_pkg::OUT_OVF: begin
          min_cost_o     <= '0;
          matrix_count_o <= '0;
          top_split_o    <= '0;
          too_many_o     <= 1'b1;
        end
        default: begin
          min_cost_o     <= '0;
          matrix_count_o <= mcmc_pkg::COUNT_O_W'(n_i);
          top_split_o    <= '0;
          too_many_o     <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/mcmc_ctrl.sv
// ----------------------------------------------------------------------------
// mcmc_ctrl
// Sequencer: loads the chain, walks diagonals, cells and splits, hands over.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmc_ctrl #(
  parameter int unsigned MAX_MATRICES = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              last_dim_i,
  output logic                                   in_stall_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output mcmc_pkg::cmd_t                         cmd_o,
  output logic [$clog2(MAX_MATRICES+1)-1:0]      dim_waddr_o,
  output logic [$clog2(MAX_MATRICES+1)-1:0]      dim_raddr_o,
  output logic [$clog2(MAX_MATRICES+1)-1:0]      i_o,
  output logic [$clog2(MAX_MATRICES+1)-1:0]      j_o,
  output logic [$clog2(MAX_MATRICES+1)-1:0]      k_o,
  output logic [$clog2(MAX_MATRICES+1)-1:0]      n_o
);

  localparam int unsigned NDIM  = MAX_MATRICES + 1;
  localparam int unsigned IDX_W = $clog2(NDIM);
  localparam int unsigned CNT_W = $clog2(NDIM + 1);

  mcmc_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] d_q, d_d, i_q, i_d, k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             full;
  logic [IDX_W-1:0] j, n;

  assign full    = (count_q == CNT_W'(NDIM));
  assign accept  = in_valid_i && (state_q == mcmc_pkg::S_IDLE);
  assign j       = i_q + d_q;
  assign n       = IDX_W'(count_q - CNT_W'(1));
  assign in_stall_o  = (state_q != mcmc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign dim_waddr_o = count_q[IDX_W-1:0];
  assign i_o = i_q;
  assign j_o = j;
  assign k_o = k_q;
  assign n_o = n;

  // Next state and loop counters.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    d_d     = d_q;
    i_d     = i_q;
    k_d     = k_q;
    unique case (state_q)
      mcmc_pkg::S_IDLE: begin
        if (accept) begin
          if (full) ovf_d = 1'b1;
          else      count_d = count_q + CNT_W'(1);
          if (last_dim_i) state_d = mcmc_pkg::S_START;
        end
      end
      mcmc_pkg::S_START: begin
        if (ovf_q || (count_q < CNT_W'(3))) begin
          state_d = mcmc_pkg::S_FINISH;
        end else begin
          d_d = IDX_W'(1);
          i_d = IDX_W'(1);
          state_d = mcmc_pkg::S_CELL0;
        end
      end
      mcmc_pkg::S_CELL0: state_d = mcmc_pkg::S_CELL1;
      mcmc_pkg::S_CELL1: state_d = mcmc_pkg::S_CELL2;
      mcmc_pkg::S_CELL2: begin
        k_d = i_q;
        state_d = mcmc_pkg::S_K0;
      end
      mcmc_pkg::S_K0: state_d = mcmc_pkg::S_K1;
      mcmc_pkg::S_K1: state_d = mcmc_pkg::S_K2;
      mcmc_pkg::S_K2: state_d = mcmc_pkg::S_K3;
      mcmc_pkg::S_K3: begin
        if (k_q == j - IDX_W'(1)) begin
          state_d = mcmc_pkg::S_WR;
        end else begin
          k_d = k_q + IDX_W'(1);
          state_d = mcmc_pkg::S_K0;
        end
      end
      mcmc_pkg::S_WR: begin
        if (j == n) begin
          if (d_q == n - IDX_W'(1)) begin
            state_d = mcmc_pkg::S_FINISH;
          end else begin
            d_d = d_q + IDX_W'(1);
            i_d = IDX_W'(1);
            state_d = mcmc_pkg::S_CELL0;
          end
        end else begin
          i_d = i_q + IDX_W'(1);
          state_d = mcmc_pkg::S_CELL0;
        end
      end
      mcmc_pkg::S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = mcmc_pkg::S_IDLE;
        end
      end
      default: state_d = mcmc_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = mcmc_pkg::OUT_ZERO;
    dim_raddr_o    = k_q;
    out_valid_d    = out_valid_q && out_stall_i;
    unique case (state_q)
      mcmc_pkg::S_IDLE:  cmd_o.dim_we = accept && !full;
      mcmc_pkg::S_CELL0: begin
        cmd_o.dim_rd = 1'b1;
        dim_raddr_o  = i_q - IDX_W'(1);
      end
      mcmc_pkg::S_CELL1: begin
        cmd_o.pim1_ld = 1'b1;
        cmd_o.dim_rd  = 1'b1;
        dim_raddr_o   = j;
      end
      mcmc_pkg::S_CELL2: begin
        cmd_o.pj_ld     = 1'b1;
        cmd_o.best_init = 1'b1;
      end
      mcmc_pkg::S_K0: begin
        cmd_o.dim_rd  = 1'b1;
        cmd_o.cost_rd = 1'b1;
      end
      mcmc_pkg::S_K1: begin
        cmd_o.mul1   = 1'b1;
        cmd_o.a_zero = (k_q == i_q);
        cmd_o.b_zero = (k_q + IDX_W'(1) == j);
      end
      mcmc_pkg::S_K2: cmd_o.mul2 = 1'b1;
      mcmc_pkg::S_K3: cmd_o.acc = 1'b1;
      mcmc_pkg::S_WR: cmd_o.cost_wr = 1'b1;
      mcmc_pkg::S_FINISH: begin
        if (ovf_q)                        cmd_o.out_kind = mcmc_pkg::OUT_OVF;
        else if (count_q >= CNT_W'(3))    cmd_o.out_kind = mcmc_pkg::OUT_BEST;
        else                              cmd_o.out_kind = mcmc_pkg::OUT_ZERO;
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcmc_pkg::S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      d_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      d_q         <= d_d;
      i_q         <= i_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/matrix_chain_min_cost.sv
// ----------------------------------------------------------------------------
// matrix_chain_min_cost
// Minimum scalar-multiplication cost of a matrix chain by dynamic programming.
//
// The input channel takes the chain's dimensions p[0..n], one per transfer,
// in chain order; the transfer with last_dim_i set closes the chain. Loading
// takes one transfer per cycle. After the last transfer the sequencer fills
// the cost table diagonal by diagonal; for each cell it fetches the two outer
// dimensions, then for each split candidate it reads memory, does the first
// multiply and the second multiply and compares, and last writes the cell.
// The single cost-table write port and the shared multiplier chain set how
// long the fill takes. One result transfer follows per chain.
// The input is stalled from the last transfer until the result is in the
// output register; a result that the receiver stalls stays there while the
// next chain loads, and the next result waits for it to go. Reset empties the
// chain and drops any pending result; the tables need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_min_cost #(
  parameter int unsigned MAX_MATRICES = 16,
  parameter int unsigned DIM_BITS     = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [mcmc_pkg::DIM_IN_W-1:0]     dim_value_i,
  input  wire logic                              last_dim_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [mcmc_pkg::COST_O_W-1:0]          min_cost_o,
  output logic [mcmc_pkg::COUNT_O_W-1:0]         matrix_count_o,
  output logic [mcmc_pkg::SPLIT_O_W-1:0]         top_split_o,
  output logic                                   too_many_o
);

  localparam int unsigned IDX_W = $clog2(MAX_MATRICES + 1);

  mcmc_pkg::cmd_t   cmd;
  logic [IDX_W-1:0] dim_waddr, dim_raddr, idx_i, idx_j, idx_k, idx_n;

  // The controller owns every counter and the handshakes.
  mcmc_ctrl #(
    .MAX_MATRICES(MAX_MATRICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_dim_i  (last_dim_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .dim_waddr_o (dim_waddr),
    .dim_raddr_o (dim_raddr),
    .i_o         (idx_i),
    .j_o         (idx_j),
    .k_o         (idx_k),
    .n_o         (idx_n)
  );

  // The datapath holds the memories, arithmetic and the result register.
  mcmc_dpath #(
    .MAX_MATRICES(MAX_MATRICES),
    .DIM_BITS    (DIM_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .dim_waddr_i    (dim_waddr),
    .dim_raddr_i    (dim_raddr),
    .i_i            (idx_i),
    .j_i            (idx_j),
    .k_i            (idx_k),
    .n_i            (idx_n),
    .dim_value_i    (dim_value_i),
    .min_cost_o     (min_cost_o),
    .matrix_count_o (matrix_count_o),
    .top_split_o    (top_split_o),
    .too_many_o     (too_many_o)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the matrix-chain minimum-cost block.
//
// Chains of dimensions are sent one transfer at a time. The scoreboard keeps
// its own copy of the chain, and when the closing dimension is accepted it
// runs the diagonal cost fill itself and queues the expected result. Each
// result transfer is then checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
`default_nettype none

class chain_scoreboard;
  localparam int NDIM = 17;

  logic [15:0] dims[NDIM];
  int unsigned dim_count;
  bit          overflow_seen;

  logic [51:0] cost_q[$];
  logic [4:0]  count_q[$];
  logic [3:0]  split_q[$];
  logic        many_q[$];
  int unsigned errors;

  function new();
    dim_count = 0;
    overflow_seen = 0;
    errors = 0;
  endfunction

  // Saturating helpers on the 64-bit internal cost.
  function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
  endfunction

  // Notes one accepted dimension; the closing one produces an expectation.
  function void note_dim(logic [15:0] dim, logic last);
    logic [63:0] cost[NDIM][NDIM];
    logic [3:0]  split[NDIM][NDIM];
    logic [63:0] best, c;
    int unsigned n, bk;
    if (dim_count < NDIM) begin
      dims[dim_count] = dim;
      dim_count++;
    end else begin
      overflow_seen = 1;
    end
    if (!last) return;
    if (overflow_seen) begin
      cost_q.push_back('0);
      count_q.push_back('0);
      split_q.push_back('0);
      many_q.push_back(1'b1);
    end else begin
      n = dim_count - 1;
      cost[1][n] = 0;
      split[1][n] = 0;
      if (n >= 2) begin
        for (int i = 1; i <= n; i++) cost[i][i] = 0;
        for (int d = 1; d < n; d++) begin
          for (int i = 1; i + d <= n; i++) begin
            best = {64{1'b1}};
            bk = i;
            for (int k = i; k < i + d; k++) begin
              c = add_sat(cost[i][k], cost[k+1][i+d]);
              c = add_sat(c, mul_sat(mul_sat(64'(dims[i-1]), 64'(dims[k])),
                                     64'(dims[i+d])));
              if (c < best) begin
                best = c;
                bk = k;
              end
            end
            cost[i][i+d] = best;
            split[i][i+d] = 4'(bk);
          end
        end
      end
      cost_q.push_back(cost[1][n][51:0]);
      count_q.push_back(5'(n));
      split_q.push_back(split[1][n]);
      many_q.push_back(1'b0);
    end
    dim_count = 0;
    overflow_seen = 0;
  endfunction

  function void check_result(logic [51:0] cost, logic [4:0] cnt, logic [3:0] spl,
                             logic many);
    if (cost_q.size() == 0) begin
      $display("%0t: result with none expected: cost %0d count %0d", $time, cost, cnt);
      errors++;
      return;
    end
    if (cost !== cost_q[0]) begin
      $display("%0t: min_cost expected %0d actual %0d", $time, cost_q[0], cost);
      errors++;
    end
    if (cnt !== count_q[0]) begin
      $display("%0t: matrix_count expected %0d actual %0d", $time, count_q[0], cnt);
      errors++;
    end
    if (spl !== split_q[0]) begin
      $display("%0t: top_split expected %0d actual %0d", $time, split_q[0], spl);
      errors++;
    end
    if (many !== many_q[0]) begin
      $display("%0t: too_many expected %0d actual %0d", $time, many_q[0], many);
      errors++;
    end
    void'(cost_q.pop_front());
    void'(count_q.pop_front());
    void'(split_q.pop_front());
    void'(many_q.pop_front());
  endfunction

  function int unsigned pending();
    return cost_q.size();
  endfunction
endclass

module tb_top;
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] dim_value_i;
  logic        last_dim_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [51:0] min_cost_o;
  logic [4:0]  matrix_count_o;
  logic [3:0]  top_split_o;
  logic        too_many_o;

  chain_scoreboard chains = new();
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned stall_mode;

  // About 1950 items make some hundreds of chains, some of them full chains of
  // sixteen; this ceiling leaves ample room over their run time.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  matrix_chain_min_cost DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .dim_value_i   (dim_value_i),
    .last_dim_i    (last_dim_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .min_cost_o    (min_cost_o),
    .matrix_count_o(matrix_count_o),
    .top_split_o   (top_split_o),
    .too_many_o    (too_many_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls on a slowly changing pattern of its own: sometimes
  // never, sometimes lightly, sometimes heavily.
  initial out_stall_i = 1'b0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Results are sampled at the edge, before any nonblocking update lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      chains.check_result(min_cost_o, matrix_count_o, top_split_o, too_many_o);
  end

  // Sends one dimension and holds it until the transfer is taken. The sender
  // works in bursts; between bursts it idles for a random gap.
  task automatic send_dim(input logic [15:0] dim, input logic last);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i  <= 1'b1;
    dim_value_i <= dim;
    last_dim_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chains.note_dim(dim, last);
    burst_left--;
    items_sent++;
  endtask

  // Random dimension value: small half the time, otherwise all ones, zero or fully random.
  function automatic logic [15:0] rand_dim();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'(0);
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic send_chain(input int unsigned ndims, input int unsigned mode);
    logic [15:0] d;
    for (int i = 0; i < ndims; i++) begin
      case (mode)
        1: d = 16'hFFFF;
        2: d = 16'(0);
        3: d = 16'(7);
        default: d = rand_dim();
      endcase
      send_dim(d, i == ndims - 1);
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    dim_value_i = '0;
    last_dim_i  = 1'b0;
    cycle_count = 0;
    items_sent  = 0;
    burst_left  = 0;
    stall_mode  = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: empty and single-matrix chains, extreme dimensions, ties, the
    // largest chain and one chain that overflows the dimension store.
    send_chain(1, 0);
    send_chain(2, 0);
    send_chain(3, 1);
    send_chain(4, 3);
    send_chain(3, 2);
    send_chain(17, 1);
    send_chain(19, 0);

    // Random: well-formed chains, mostly short, a few full length and a few
    // overflowing.
    while (items_sent < 1950) begin
      case ($urandom_range(0, 19))
        0: send_chain($urandom_range(18, 22), 0);
        1: send_chain(17, 0);
        2: send_chain($urandom_range(1, 2), 0);
        3: send_chain($urandom_range(3, 17), 1);
        default: send_chain($urandom_range(3, 9), 0);
      endcase
    end
    in_valid_i <= 1'b0;
    last_dim_i <= 1'b0;

    while (chains.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (chains.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
